[rtl/rad_pkg.sv]
`timescale 1ns / 1ps
package rad_pkg;

   // Pool sizing
   localparam int MAX_SLOTS  = 4096;
   localparam int MAX_RANGES = 64;
   localparam int FRAMES     = 4;
   localparam int MAX_TEMPS  = 64;

   // Widths that follow from the sizing
   localparam int RIDX_W = $clog2(MAX_RANGES);
   localparam int RCNT_W = $clog2(MAX_RANGES + 1);
   localparam int TCNT_W = $clog2(MAX_TEMPS + 1);
   localparam int TDEPTH = FRAMES * MAX_TEMPS;
   localparam int TIDX_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int FR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // Fixed field widths
   localparam int SLOT_W = 13;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [12:0] TOTAL_RESET = 13'd4096;
   localparam logic [10:0] HSIZE_RESET = 11'd32;

   typedef enum logic [2:0] {
      CMD_ALLOC   = 3'd0,
      CMD_TEMP    = 3'd1,
      CMD_FREE    = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_REINIT  = 3'd4
   } rad_cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SPACE     = 3'd1,
      ST_LIST_FULL = 3'd2,
      ST_TEMP_FULL = 3'd3,
      ST_BAD       = 3'd4
   } rad_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL = 2'd0,
      CSR_HSIZE = 2'd1,
      CSR_GBASE = 2'd2,
      CSR_CBASE = 2'd3
   } rad_csr_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_REINIT, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
      S_FREE_GO, S_FREE_DEC, S_INS_RD, S_INS_WR, S_INS_PUT, S_FREE_END,
      S_TMP_RD, S_TMP_LD, S_DONE, S_WAIT
   } rad_state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [12:0] count;
      logic [11:0] start_index;
      logic [1:0]  frame;
   } rad_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] start_slot;
      logic [12:0] granted;
      logic [63:0] gpu_address;
      logic [63:0] cpu_address;
      logic [6:0]  free_ranges;
   } rad_rsp_type;

   // Result fields produced by the sequencer
   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] start_slot;
      logic [12:0] granted;
      logic [6:0]  free_ranges;
   } rad_res_type;

   typedef struct packed {
      logic [10:0] handle_size;
      logic [63:0] gpu_base;
      logic [63:0] cpu_base;
   } rad_cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0] first;
      logic [SLOT_W-1:0] limit;
   } rad_range_type;

   typedef struct packed {
      logic [SLOT_W-1:0] first;
      logic [SLOT_W-1:0] length;
   } rad_temp_type;

endpackage

[rtl/range_allocator_double_ended_core.sv]
`timescale 1ns / 1ps
// Range allocator over a pool of handle slots, keeping a sorted free list.
// Request: start with req_data while busy is low; the request is taken at
// that edge and busy rises until the response has been sent.
// Response: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver cannot stall it.
// Config: csr_we/csr_index/csr_wdata write a register at once; the user must write only while idle, not enforced.
// Flow: each command walks the free list through one memory read port;
// removing or inserting an entry shifts the tail entry by entry, and a
// frame release repeats a full free per recorded temporary. Finally the
// addresses are formed in a multiply then add unit: the product register,
// then the address registers.
// Reset: synchronous; in the cycle after reset the initial range is written
// and busy falls. The free list and temporary lists hold no clearing pass.
module range_allocator_double_ended_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rad_pkg::rad_req_type  req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output rad_pkg::rad_rsp_type  rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_wdata
);
   import rad_pkg::*;

   logic [12:0] total_ff;
   logic [10:0] hsize_ff;
   logic [63:0] gbase_ff;
   logic [63:0] cbase_ff;

   rad_cfg_type cfg;
   rad_res_type res;
   logic        addr_go;
   logic        addr_done;
   logic [63:0] gpu_address;
   logic [63:0] cpu_address;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         hsize_ff <= HSIZE_RESET;
         gbase_ff <= '0;
         cbase_ff <= '0;
      end else if (csr_we) begin
         case (rad_csr_type'(csr_index))
            CSR_TOTAL: total_ff <= csr_wdata[12:0];
            CSR_HSIZE: hsize_ff <= csr_wdata[10:0];
            CSR_GBASE: gbase_ff <= csr_wdata;
            CSR_CBASE: cbase_ff <= csr_wdata;
            default:   total_ff <= total_ff;
         endcase
      end
   end

   assign cfg.handle_size = hsize_ff;
   assign cfg.gpu_base    = gbase_ff;
   assign cfg.cpu_base    = cbase_ff;

   rad_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req           (req_data),
      .total_handles (total_ff),
      .addr_done     (addr_done),
      .busy          (busy),
      .addr_go       (addr_go),
      .res           (res)
   );

   rad_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .go          (addr_go),
      .slot        (res.start_slot),
      .cfg         (cfg),
      .done        (addr_done),
      .gpu_address (gpu_address),
      .cpu_address (cpu_address)
   );

   assign rsp_valid            = addr_done;
   assign rsp_data.status      = res.status;
   assign rsp_data.start_slot  = res.start_slot;
   assign rsp_data.granted     = res.granted;
   assign rsp_data.gpu_address = gpu_address;
   assign rsp_data.cpu_address = cpu_address;
   assign rsp_data.free_ranges = res.free_ranges;

   // A response only comes out of a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   // A taken request keeps the block busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request taken but not busy");

   // One response per request
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");

   // Free list never exceeds its capacity
   a_ranges_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.free_ranges) <= MAX_RANGES))
      else $error("free list overflow");

endmodule

[rtl/rad_addr.sv]
`timescale 1ns / 1ps
module rad_addr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [11:0]          slot,
   input  rad_pkg::rad_cfg_type cfg,
   output logic                 done,
   output logic [63:0]          gpu_address,
   output logic [63:0]          cpu_address
);
   import rad_pkg::*;

   logic [22:0] prod_ff, prod_in;
   logic        mul_vld_ff;
   logic        done_ff;
   logic [63:0] gpu_ff, gpu_in;
   logic [63:0] cpu_ff, cpu_in;

   // slot times stride, then the two base adds
   assign prod_in = 23'(slot) * 23'(cfg.handle_size);
   assign gpu_in  = cfg.gpu_base + 64'(prod_ff);
   assign cpu_in  = cfg.cpu_base + 64'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= go;
         done_ff    <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      gpu_ff  <= gpu_in;
      cpu_ff  <= cpu_in;
   end

   assign done        = done_ff;
   assign gpu_address = gpu_ff;
   assign cpu_address = cpu_ff;

endmodule

[rtl/rad_seq.sv]
`timescale 1ns / 1ps
module rad_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rad_pkg::rad_req_type req,
   input  logic [12:0]          total_handles,
   input  logic                 addr_done,
   output logic                 busy,
   output logic                 addr_go,
   output rad_pkg::rad_res_type res
);
   import rad_pkg::*;

   // Free range list and per-frame temporary lists
   rad_range_type rmem [MAX_RANGES];
   rad_temp_type  tmem [TDEPTH];

   rad_state_type state_ff, state_in;

   logic [2:0]        op_ff, op_in;
   logic [12:0]       cnt_ff, cnt_in;
   logic [FR_W-1:0]   fidx_ff, fidx_in;
   logic [SLOT_W-1:0] fstart_ff, fstart_in;
   logic [SLOT_W-1:0] flen_ff, flen_in;
   logic [2:0]        fst_ff, fst_in;
   logic [RCNT_W-1:0] idx_ff, idx_in;
   logic [RCNT_W-1:0] kk_ff, kk_in;
   logic [RCNT_W-1:0] rcount_ff, rcount_in;
   logic [TCNT_W-1:0] tj_ff, tj_in;
   logic [TCNT_W-1:0] tcount_ff [FRAMES];
   logic [TCNT_W-1:0] tcount_in [FRAMES];
   rad_range_type     prev_ff, prev_in;
   rad_range_type     nxt_ff, nxt_in;
   logic              have_prev_ff, have_prev_in;
   logic [2:0]        status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [12:0]       amount_ff, amount_in;

   rad_range_type     rdat_ff;
   rad_temp_type      tdat_ff;
   logic              rwe, twe;
   logic [RIDX_W-1:0] rwaddr, rraddr;
   rad_range_type     rwdata;
   logic [TIDX_W-1:0] twaddr, traddr;
   rad_temp_type      twdata;

   // Shared decode
   logic [SLOT_W-1:0] clamp_total;
   logic [SLOT_W-1:0] alloc_first, temp_lim;
   logic              len_fit, alloc_empty, temp_empty, first_le;
   logic [SLOT_W:0]   free_end;
   logic              free_bad, has_next, prev_ovl, next_ovl, pa, na, list_full;
   logic              idx_last, tj_last, is_free_op;
   logic              req_frame_ok, req_tfull;
   logic [FR_W-1:0]   rfidx;
   logic [TIDX_W-1:0] tbase;
   logic              accept;

   assign accept      = start && (state_ff == S_IDLE);
   assign clamp_total = (32'(total_handles) > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : total_handles;
   assign len_fit     = (rdat_ff.limit - rdat_ff.first) >= cnt_ff;
   assign alloc_first = rdat_ff.first + cnt_ff;
   assign temp_lim    = rdat_ff.limit - cnt_ff;
   assign alloc_empty = alloc_first == rdat_ff.limit;
   assign temp_empty  = rdat_ff.first == temp_lim;
   assign first_le    = rdat_ff.first <= fstart_ff;
   assign free_end    = {1'b0, fstart_ff} + {1'b0, flen_ff};
   assign free_bad    = (flen_ff == '0) || (32'(free_end) > MAX_SLOTS);
   assign has_next    = idx_ff < rcount_ff;
   assign prev_ovl    = have_prev_ff && (prev_ff.limit > fstart_ff);
   assign next_ovl    = has_next && (free_end > {1'b0, nxt_ff.first});
   assign pa          = have_prev_ff && (prev_ff.limit == fstart_ff);
   assign na          = has_next && ({1'b0, nxt_ff.first} == free_end);
   assign list_full   = 32'(rcount_ff) >= MAX_RANGES;
   assign idx_last    = RCNT_W'(idx_ff + 1'b1) == rcount_ff;
   assign tj_last     = TCNT_W'(tj_ff + 1'b1) == tcount_ff[fidx_ff];
   assign is_free_op  = (op_ff == CMD_FREE) || (op_ff == CMD_RELEASE);
   assign req_frame_ok = 32'(req.frame) < FRAMES;
   assign rfidx       = FR_W'(req.frame);
   assign req_tfull   = 32'(tcount_ff[rfidx]) >= MAX_TEMPS;
   assign tbase       = TIDX_W'(fidx_ff) * TIDX_W'(MAX_TEMPS);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:   state_in = S_IDLE;
         S_REINIT: state_in = S_DONE;
         S_IDLE: begin
            if (accept) begin
               case (rad_cmd_type'(req.cmd))
                  CMD_ALLOC: begin
                     if (req.count == '0 || rcount_ff == '0) state_in = S_DONE;
                     else state_in = S_SCAN_RD;
                  end
                  CMD_TEMP: begin
                     if (req.count == '0 || !req_frame_ok || req_tfull || rcount_ff == '0)
                        state_in = S_DONE;
                     else state_in = S_SCAN_RD;
                  end
                  CMD_FREE: state_in = S_FREE_GO;
                  CMD_RELEASE: begin
                     if (!req_frame_ok || tcount_ff[rfidx] == '0) state_in = S_DONE;
                     else state_in = S_TMP_RD;
                  end
                  CMD_REINIT: state_in = S_REINIT;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            case (rad_cmd_type'(op_ff))
               CMD_ALLOC: begin
                  if (len_fit) state_in = alloc_empty ? S_SHIFT_RD : S_DONE;
                  else state_in = idx_last ? S_DONE : S_SCAN_RD;
               end
               CMD_TEMP: begin
                  if (len_fit) state_in = temp_empty ? S_SHIFT_RD : S_DONE;
                  else state_in = (idx_ff == '0) ? S_DONE : S_SCAN_RD;
               end
               default: begin
                  if (first_le) state_in = idx_last ? S_FREE_DEC : S_SCAN_RD;
                  else state_in = S_FREE_DEC;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (RCNT_W'(idx_ff + 1'b1) < rcount_ff) state_in = S_SHIFT_WR;
            else state_in = is_free_op ? S_FREE_END : S_DONE;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_FREE_GO: begin
            if (free_bad) state_in = S_FREE_END;
            else state_in = (rcount_ff == '0) ? S_FREE_DEC : S_SCAN_RD;
         end
         S_FREE_DEC: begin
            if (prev_ovl || next_ovl) state_in = S_FREE_END;
            else if (pa && na) state_in = S_SHIFT_RD;
            else if (pa || na || list_full) state_in = S_FREE_END;
            else state_in = S_INS_RD;
         end
         S_INS_RD:  state_in = (kk_ff > idx_ff) ? S_INS_WR : S_INS_PUT;
         S_INS_WR:  state_in = S_INS_RD;
         S_INS_PUT: state_in = S_FREE_END;
         S_FREE_END: begin
            if (op_ff == CMD_RELEASE && !tj_last) state_in = S_TMP_RD;
            else state_in = S_DONE;
         end
         S_TMP_RD: state_in = S_TMP_LD;
         S_TMP_LD: state_in = S_FREE_GO;
         S_DONE:   state_in = S_WAIT;
         S_WAIT:   state_in = addr_done ? S_IDLE : S_WAIT;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      fidx_in      = fidx_ff;
      fstart_in    = fstart_ff;
      flen_in      = flen_ff;
      fst_in       = fst_ff;
      idx_in       = idx_ff;
      kk_in        = kk_ff;
      rcount_in    = rcount_ff;
      tj_in        = tj_ff;
      tcount_in    = tcount_ff;
      prev_in      = prev_ff;
      nxt_in       = nxt_ff;
      have_prev_in = have_prev_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      amount_in    = amount_ff;
      rwe          = 1'b0;
      rwaddr       = idx_ff[RIDX_W-1:0];
      rwdata       = rdat_ff;
      rraddr       = idx_ff[RIDX_W-1:0];
      twe          = 1'b0;
      twaddr       = tbase + TIDX_W'(tcount_ff[fidx_ff]);
      twdata       = '{first: temp_lim, length: cnt_ff};
      traddr       = tbase + TIDX_W'(tj_ff);
      addr_go      = 1'b0;
      case (state_ff)
         S_INIT, S_REINIT: begin
            // one range covering the whole pool
            rwe       = clamp_total != '0;
            rwaddr    = '0;
            rwdata    = '{first: '0, limit: clamp_total};
            rcount_in = (clamp_total != '0) ? RCNT_W'(1) : '0;
            for (int f = 0; f < FRAMES; f++) tcount_in[f] = '0;
         end
         S_IDLE: begin
            if (accept) begin
               op_in     = req.cmd;
               cnt_in    = req.count;
               fidx_in   = rfidx;
               fstart_in = SLOT_W'(req.start_index);
               flen_in   = req.count;
               slot_in   = '0;
               amount_in = '0;
               tj_in     = '0;
               status_in = ST_BAD;
               case (rad_cmd_type'(req.cmd))
                  CMD_ALLOC: begin
                     idx_in = '0;
                     if (req.count != '0) status_in = ST_SPACE;
                  end
                  CMD_TEMP: begin
                     idx_in = RCNT_W'(rcount_ff - 1'b1);
                     if (req.count != '0 && req_frame_ok)
                        status_in = req_tfull ? ST_TEMP_FULL : ST_SPACE;
                  end
                  CMD_RELEASE: begin
                     if (req_frame_ok) status_in = ST_OK;
                  end
                  CMD_REINIT: status_in = ST_OK;
                  default: status_in = status_in;
               endcase
            end
         end
         S_SCAN_CHK: begin
            case (rad_cmd_type'(op_ff))
               CMD_ALLOC: begin
                  if (len_fit) begin
                     status_in = ST_OK;
                     slot_in   = rdat_ff.first;
                     amount_in = cnt_ff;
                     rwe       = !alloc_empty;
                     rwdata    = '{first: alloc_first, limit: rdat_ff.limit};
                  end else begin
                     idx_in = RCNT_W'(idx_ff + 1'b1);
                  end
               end
               CMD_TEMP: begin
                  if (len_fit) begin
                     status_in = ST_OK;
                     slot_in   = temp_lim;
                     amount_in = cnt_ff;
                     rwe       = !temp_empty;
                     rwdata    = '{first: rdat_ff.first, limit: temp_lim};
                     twe       = 1'b1;
                     tcount_in[fidx_ff] = TCNT_W'(tcount_ff[fidx_ff] + 1'b1);
                  end else begin
                     idx_in = RCNT_W'(idx_ff - 1'b1);
                  end
               end
               default: begin
                  // free scan: remember the last range starting at or below
                  if (first_le) begin
                     prev_in      = rdat_ff;
                     have_prev_in = 1'b1;
                     idx_in       = RCNT_W'(idx_ff + 1'b1);
                  end else begin
                     nxt_in = rdat_ff;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            rraddr = RIDX_W'(idx_ff + 1'b1);
            if (!(RCNT_W'(idx_ff + 1'b1) < rcount_ff)) begin
               rcount_in = RCNT_W'(rcount_ff - 1'b1);
               fst_in    = ST_OK;
            end
         end
         S_SHIFT_WR: begin
            rwe    = 1'b1;
            rwaddr = idx_ff[RIDX_W-1:0];
            rwdata = rdat_ff;
            idx_in = RCNT_W'(idx_ff + 1'b1);
         end
         S_FREE_GO: begin
            idx_in       = '0;
            have_prev_in = 1'b0;
            if (free_bad) fst_in = ST_BAD;
         end
         S_FREE_DEC: begin
            kk_in = rcount_ff;
            if (prev_ovl || next_ovl) begin
               fst_in = ST_BAD;
            end else if (pa) begin
               // grow the previous range, absorbing the next one when both touch
               rwe    = 1'b1;
               rwaddr = RIDX_W'(idx_ff - 1'b1);
               rwdata = '{first: prev_ff.first,
                          limit: na ? nxt_ff.limit : SLOT_W'(free_end)};
               fst_in = ST_OK;
            end else if (na) begin
               rwe    = 1'b1;
               rwaddr = idx_ff[RIDX_W-1:0];
               rwdata = '{first: fstart_ff, limit: nxt_ff.limit};
               fst_in = ST_OK;
            end else if (list_full) begin
               fst_in = ST_LIST_FULL;
            end
         end
         S_INS_RD: begin
            rraddr = RIDX_W'(kk_ff - 1'b1);
         end
         S_INS_WR: begin
            rwe    = 1'b1;
            rwaddr = kk_ff[RIDX_W-1:0];
            rwdata = rdat_ff;
            kk_in  = RCNT_W'(kk_ff - 1'b1);
         end
         S_INS_PUT: begin
            rwe       = 1'b1;
            rwaddr    = idx_ff[RIDX_W-1:0];
            rwdata    = '{first: fstart_ff, limit: SLOT_W'(free_end)};
            rcount_in = RCNT_W'(rcount_ff + 1'b1);
            fst_in    = ST_OK;
         end
         S_FREE_END: begin
            if (op_ff == CMD_RELEASE) begin
               if (status_ff == ST_OK && fst_ff != ST_OK) status_in = fst_ff;
               tj_in = TCNT_W'(tj_ff + 1'b1);
               if (tj_last) tcount_in[fidx_ff] = '0;
            end else begin
               status_in = fst_ff;
               if (fst_ff == ST_OK) begin
                  slot_in   = fstart_ff;
                  amount_in = flen_ff;
               end
            end
         end
         S_TMP_LD: begin
            fstart_in = tdat_ff.first;
            flen_in   = tdat_ff.length;
         end
         S_DONE: addr_go = 1'b1;
         default: addr_go = 1'b0;
      endcase
   end

   // Memories
   always_ff @(posedge clock) begin
      if (rwe) rmem[rwaddr] <= rwdata;
      rdat_ff <= rmem[rraddr];
   end

   always_ff @(posedge clock) begin
      if (twe) tmem[twaddr] <= twdata;
      tdat_ff <= tmem[traddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         rcount_ff <= '0;
         for (int f = 0; f < FRAMES; f++) tcount_ff[f] <= '0;
      end else begin
         state_ff  <= state_in;
         rcount_ff <= rcount_in;
         tcount_ff <= tcount_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cnt_ff       <= cnt_in;
      fidx_ff      <= fidx_in;
      fstart_ff    <= fstart_in;
      flen_ff      <= flen_in;
      fst_ff       <= fst_in;
      idx_ff       <= idx_in;
      kk_ff        <= kk_in;
      tj_ff        <= tj_in;
      prev_ff      <= prev_in;
      nxt_ff       <= nxt_in;
      have_prev_ff <= have_prev_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      amount_ff    <= amount_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign res.status      = status_ff;
   assign res.start_slot  = slot_ff[11:0];
   assign res.granted     = amount_ff;
   assign res.free_ranges = 7'(rcount_ff);

endmodule
